// ===== design/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the FIFO page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

  localparam int PAGE_W = 32;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 12;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 12'd4;
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== design/fpr_if.sv =====
// ----------------------------------------------------------------------------
// fpr_if
// Valid/ready channels: frame count writes, page requests, results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpr_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [fpr_pkg::CFG_W-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

interface fpr_req_if;
  logic                      valid;
  logic                      ready;
  logic [fpr_pkg::PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface fpr_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic                     replaced;
  logic [fpr_pkg::CNT_W-1:0] request_total;
  logic [fpr_pkg::CNT_W-1:0] fault_total;
  logic [fpr_pkg::CFG_W-1:0] frames_loaded;

  modport source (output valid, output hit, output replaced, output request_total,
                  output fault_total, output frames_loaded, input ready);
  modport sink   (input valid, input hit, input replaced, input request_total,
                  input fault_total, input frames_loaded, output ready);
endinterface

`default_nettype wire

// ===== design/fpr_frame_mem.sv =====
// ----------------------------------------------------------------------------
// fpr_frame_mem
// Page store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_frame_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [fpr_pkg::PAGE_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output      logic [fpr_pkg::PAGE_W-1:0] rdata
);

  logic [fpr_pkg::PAGE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/fpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpr_ctrl
// Scan sequencer, victim pointer, fill count, counters and result register.
// Frames below the fill count are the valid ones.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_ctrl #(
  parameter int MAX_FRAMES = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [fpr_pkg::CFG_W-1:0]  frames_in_use,
  fpr_req_if.sink                         req,
  fpr_rsp_if.source                       rsp,
  output      logic                       mem_we,
  output      logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] mem_waddr,
  output      logic [fpr_pkg::PAGE_W-1:0] mem_wdata,
  output      logic                       mem_re,
  output      logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] mem_raddr,
  input  wire logic [fpr_pkg::PAGE_W-1:0] mem_rdata
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  fpr_pkg::state_t state, state_next;

  logic [fpr_pkg::PAGE_W-1:0] page;
  logic [CW-1:0]              n_lat;
  logic [CW-1:0]              limit;
  logic [CW-1:0]              issue_cnt;
  logic [CW-1:0]              loaded;
  logic [AW-1:0]              victim;
  logic                       cmp_valid;
  logic                       hit_flag;
  logic [fpr_pkg::CNT_W-1:0]  req_count;
  logic [fpr_pkg::CNT_W-1:0]  fault_count;

  logic [CW-1:0]              n_eff;
  logic [CW-1:0]              limit_calc;
  logic [31:0]                cfg_ext;
  logic                       accept;
  logic                       hit_now;
  logic                       issue;
  logic                       scan_done;
  logic                       out_free;
  logic                       finish_go;
  logic [AW-1:0]              slot;
  logic                       slot_valid;
  logic [CW-1:0]              slot_inc;
  logic [AW-1:0]              victim_next;
  logic [CW-1:0]              loaded_next;
  logic [fpr_pkg::CNT_W-1:0]  req_count_next;
  logic [fpr_pkg::CNT_W-1:0]  fault_count_next;

  // effective frame count, clamped to 1 .. MAX_FRAMES
  always_comb begin
    cfg_ext = 32'(frames_in_use);
    if (cfg_ext == 32'd0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > 32'(MAX_FRAMES)) begin
      n_eff = CW'(MAX_FRAMES);
    end else begin
      n_eff = CW'(cfg_ext);
    end
    limit_calc = (n_eff < loaded) ? n_eff : loaded;
  end

  assign accept    = req.valid && req.ready;
  assign hit_now   = cmp_valid && (mem_rdata == page);
  assign issue     = (state == fpr_pkg::ST_SCAN) && (issue_cnt < limit) && !hit_now;
  assign scan_done = hit_now || ((issue_cnt == limit) && !cmp_valid);
  assign out_free  = !rsp.valid || rsp.ready;
  assign finish_go = (state == fpr_pkg::ST_FINISH) && out_free;

  // victim slot and update values
  always_comb begin
    slot        = (CW'(victim) >= n_lat) ? '0 : victim;
    slot_valid  = CW'(slot) < loaded;
    slot_inc    = CW'(slot) + CW'(1);
    victim_next = (slot_inc >= n_lat) ? '0 : slot_inc[AW-1:0];
    loaded_next = loaded;
    fault_count_next = fault_count;
    if (!hit_flag) begin
      if (slot_valid) begin
        if (fault_count != fpr_pkg::CNT_MAX) begin
          fault_count_next = fault_count + fpr_pkg::CNT_W'(1);
        end
      end else begin
        loaded_next = loaded + CW'(1);
      end
    end
    req_count_next = (req_count == fpr_pkg::CNT_MAX) ? req_count
                                                     : req_count + fpr_pkg::CNT_W'(1);
  end

  always_comb begin
    state_next = state;
    case (state)
      fpr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = fpr_pkg::ST_SCAN;
        end
      end
      fpr_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = fpr_pkg::ST_FINISH;
        end
      end
      fpr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = fpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready = (state == fpr_pkg::ST_IDLE);
    mem_re    = issue;
    mem_raddr = issue_cnt[AW-1:0];
    mem_we    = finish_go && !hit_flag;
    mem_waddr = slot;
    mem_wdata = page;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fpr_pkg::ST_IDLE;
      victim      <= '0;
      loaded      <= '0;
      req_count   <= '0;
      fault_count <= '0;
      cmp_valid   <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (finish_go) begin
        req_count   <= req_count_next;
        fault_count <= fault_count_next;
        loaded      <= loaded_next;
        if (!hit_flag) begin
          victim <= victim_next;
        end
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page      <= req.page_number;
      n_lat     <= n_eff;
      limit     <= limit_calc;
      issue_cnt <= '0;
      hit_flag  <= 1'b0;
    end else begin
      if (issue) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      if ((state == fpr_pkg::ST_SCAN) && hit_now) begin
        hit_flag <= 1'b1;
      end
    end
    if (finish_go) begin
      rsp.hit           <= hit_flag;
      rsp.replaced      <= !hit_flag && slot_valid;
      rsp.request_total <= req_count_next;
      rsp.fault_total   <= fault_count_next;
      rsp.frames_loaded <= fpr_pkg::CFG_W'(loaded_next);
    end
  end

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= CW'(MAX_FRAMES))
    else $error("fill count above frame capacity");

  a_victim_in_fill: assert property (@(posedge clk) disable iff (rst)
    CW'(victim) <= loaded)
    else $error("victim pointer beyond filled frames");

  a_read_valid_only: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (issue_cnt < loaded))
    else $error("read of a frame that was never loaded");

  a_write_on_miss: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (rsp.valid && !rsp.hit))
    else $error("frame write without a miss result");

endmodule

`default_nettype wire

// ===== design/fifo_page_replacement.sv =====
// ----------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement: searches loaded frames for each page, fills or
// replaces at a round-robin victim pointer, reports hit, fault and counts.
//
//   channel  dir  beat payload
//   cfg      in   frames_in_use
//   req      in   page_number
//   rsp      out  hit, replaced, request_total, fault_total, frames_loaded
//
// One request at a time. With L = min(n, loaded), n the clamped frame count,
// the scan reads up to L frames, one frame per cycle through the single read
// port of the page memory, and stops early on a hit. req is ready again in
// the same cycle as the result becomes valid.
// rst is synchronous; it clears counters, fill count and victim pointer.
// cfg is always ready. A held result stalls the next request in its last
// step; req is ready again once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_page_replacement #(
  parameter int MAX_FRAMES = 2048
) (
  input  wire logic clk,
  input  wire logic rst,
  fpr_cfg_if.sink   cfg,
  fpr_req_if.sink   req,
  fpr_rsp_if.source rsp
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [fpr_pkg::CFG_W-1:0]  frames_in_use;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [fpr_pkg::PAGE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [fpr_pkg::PAGE_W-1:0] mem_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= fpr_pkg::FRAMES_RESET;
    end else if (cfg.valid) begin
      frames_in_use <= cfg.frames_in_use;
    end
  end

  fpr_ctrl #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .frames_in_use (frames_in_use),
    .req           (req),
    .rsp           (rsp),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  fpr_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_frame_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
